// ----- design/md5_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round functions of the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int WORD_W    = 32;
    localparam int BLK_WORDS = 16;
    localparam int BLK_AW    = 4;
    localparam int STEP_W    = 6;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_SLOT   = 6'd56;
    localparam logic [5:0] LAST_SLOT  = 6'h3F;
    localparam logic [6:0] LAST_CYCLE = 7'd65;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_COMP,
        ST_FINAL,
        ST_PAD,
        ST_OUT0,
        ST_OUT1
    } md5_state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_stage_t;

    function automatic logic [31:0] k_const(input logic [5:0] s);
        logic [31:0] k;
        case (s)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] s);
        logic [4:0] r;
        case ({s[5:4], s[1:0]})
            4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
            4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
            4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
            4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;
            default: r = 5'd21;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] s);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = s[3:0];
        case (s[5:4])
            2'd0:    idx = lo;
            2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
            2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
            default: idx = 4'(lo * 4'd7);
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] mix_fn(input logic [1:0] q, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] m;
        case (q)
            2'd0:    m = (b & c) | (~b & d);
            2'd1:    m = (b & d) | (c & ~d);
            2'd2:    m = b ^ c ^ d;
            default: m = c ^ (b | ~d);
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- design/md5_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_in_if
// Byte channel: one optional message byte and an end mark per transaction.
// ----------------------------------------------------------------------------
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;

    modport source (output valid, data_byte, byte_valid, message_end, input ready);
    modport sink   (input valid, data_byte, byte_valid, message_end, output ready);
endinterface
`default_nettype wire

// ----- design/md5_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_out_if
// Digest channel: one 64-bit digest half per transaction.
// ----------------------------------------------------------------------------
interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_half;
    logic        half_index;
    logic        last_half;

    modport source (output valid, digest_half, half_index, last_half, input ready);
    modport sink   (input valid, digest_half, half_index, last_half, output ready);
endinterface
`default_nettype wire

// ----- design/md5_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- design/md5_stream_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_stream_hash
// MD5 digest over a byte stream, block words held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   byte_ch carries one transaction per item: data_byte when byte_valid is
//   set, and message_end on the last item of a message. Items without a
//   byte and without an end are dropped.
//   digest_ch returns two transactions per message end: digest bytes 0..7
//   (half_index 0), then bytes 8..15 (half_index 1, last_half 1).
// Flow:
//   A byte item is taken whenever the hasher accepts. The item that completes a
//   64-byte block starts the compression, which holds byte_ch.ready low
//   through 64 steps of one shared round unit, a prefetch of the first
//   block word through the RAM read and pre-add registers, and a fold into
//   the chaining value. An end item walks padding and length one byte a
//   cycle and runs one or two compressions before digest_ch.valid rises.
// Reset and stall:
//   Reset loads the initial chaining value and clears the bit count and
//   byte position. The block RAM needs no clearing. While digest_ch is
//   stalled the digest halves hold and byte_ch stays not ready.
// ----------------------------------------------------------------------------
module md5_stream_hash
    import md5_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    md5_in_if.sink     byte_ch,
    md5_out_if.source  digest_ch
);

    md5_state_t state_reg, state_next;
    pad_stage_t stage_reg;

    logic [5:0]  pos_reg;
    logic [63:0] count_reg;
    logic [63:0] total_reg;
    logic        pad_active_reg;
    logic        len_done_reg;
    logic [6:0]  cyc_reg;
    logic [31:0] word_reg;
    logic [31:0] ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] pre_reg;

    logic        in_fire, out_fire;
    logic        put_en;
    logic [7:0]  put_val;
    logic [31:0] word_next;
    logic [63:0] count_next;
    logic [31:0] ram_rdata;
    logic [5:0]  pre_step, exe_step;
    logic [31:0] sum, rot;
    logic [63:0] rot_wide;

    assign in_fire  = byte_ch.valid && byte_ch.ready;
    assign out_fire = digest_ch.valid && digest_ch.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT:
            begin
                if (in_fire)
                begin
                    if (byte_ch.byte_valid && pos_reg == LAST_SLOT)
                        state_next = ST_COMP;
                    else if (byte_ch.message_end)
                        state_next = ST_PAD;
                end
            end
            ST_COMP:
            begin
                if (cyc_reg == LAST_CYCLE)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (!pad_active_reg)
                    state_next = ST_ACCEPT;
                else if (len_done_reg)
                    state_next = ST_OUT0;
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if (pos_reg == LAST_SLOT)
                    state_next = ST_COMP;
            end
            ST_OUT0:
            begin
                if (out_fire)
                    state_next = ST_OUT1;
            end
            ST_OUT1:
            begin
                if (out_fire)
                    state_next = ST_ACCEPT;
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    // Outputs and byte source
    always_comb
    begin
        byte_ch.ready         = 1'b0;
        digest_ch.valid       = 1'b0;
        digest_ch.half_index  = 1'b0;
        digest_ch.last_half   = 1'b0;
        digest_ch.digest_half = {ch_b_reg, ch_a_reg};
        put_en                = 1'b0;
        put_val               = byte_ch.data_byte;
        case (state_reg)
            ST_ACCEPT:
            begin
                byte_ch.ready = 1'b1;
                put_en        = in_fire && byte_ch.byte_valid;
            end
            ST_PAD:
            begin
                put_en = 1'b1;
                case (stage_reg)
                    PAD_MARK: put_val = PAD_BYTE;
                    PAD_LEN:  put_val = total_reg[{pos_reg[2:0], 3'b000} +: 8];
                    default:  put_val = 8'h00;
                endcase
            end
            ST_OUT0:
            begin
                digest_ch.valid = 1'b1;
            end
            ST_OUT1:
            begin
                digest_ch.valid       = 1'b1;
                digest_ch.half_index  = 1'b1;
                digest_ch.last_half   = 1'b1;
                digest_ch.digest_half = {ch_d_reg, ch_c_reg};
            end
            default: ;
        endcase
    end

    // Pack bytes little-endian; write the word when its top lane lands
    always_comb
    begin
        word_next = word_reg;
        word_next[{pos_reg[1:0], 3'b000} +: 8] = put_val;
    end

    assign count_next = count_reg + (byte_ch.byte_valid ? 64'd8 : 64'd0);

    // Prefetch two steps ahead: RAM address for cycle n, pre-add for step n-1,
    // round for step n-2
    assign pre_step = 6'(cyc_reg - 7'd1);
    assign exe_step = 6'(cyc_reg - 7'd2);

    md5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLK_WORDS)
    ) u_block_ram (
        .clk     (clk),
        .wr_en   (put_en && pos_reg[1:0] == 2'd3),
        .wr_addr (pos_reg[5:2]),
        .wr_data (word_next),
        .rd_addr (msg_index(cyc_reg[5:0])),
        .rd_data (ram_rdata)
    );

    assign sum      = pre_reg + mix_fn(exe_step[5:4], b_reg, c_reg, d_reg);
    assign rot_wide = {sum, sum} << rot_amt(exe_step);
    assign rot      = rot_wide[63:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACCEPT;
            stage_reg      <= PAD_MARK;
            pos_reg        <= '0;
            count_reg      <= '0;
            pad_active_reg <= 1'b0;
            len_done_reg   <= 1'b0;
            cyc_reg        <= '0;
            ch_a_reg       <= INIT_A;
            ch_b_reg       <= INIT_B;
            ch_c_reg       <= INIT_C;
            ch_d_reg       <= INIT_D;
        end
        else
        begin
            state_reg <= state_next;

            if (put_en)
            begin
                pos_reg <= pos_reg + 6'd1;
            end

            if (in_fire)
            begin
                count_reg <= count_next;
                if (byte_ch.message_end)
                begin
                    pad_active_reg <= 1'b1;
                    len_done_reg   <= 1'b0;
                    stage_reg      <= PAD_MARK;
                end
            end

            if (state_reg == ST_PAD)
            begin
                if (pos_reg + 6'd1 == LEN_SLOT)
                    stage_reg <= PAD_LEN;
                else if (stage_reg == PAD_MARK)
                    stage_reg <= PAD_ZERO;
                if (stage_reg == PAD_LEN && pos_reg == LAST_SLOT)
                    len_done_reg <= 1'b1;
            end

            // Step counter runs only inside a compression
            if (state_reg == ST_COMP && cyc_reg != LAST_CYCLE)
                cyc_reg <= cyc_reg + 7'd1;
            else
                cyc_reg <= '0;

            if (state_reg == ST_FINAL)
            begin
                ch_a_reg <= ch_a_reg + a_reg;
                ch_b_reg <= ch_b_reg + b_reg;
                ch_c_reg <= ch_c_reg + c_reg;
                ch_d_reg <= ch_d_reg + d_reg;
            end

            // Reload the initial value once the last half is taken
            if (state_reg == ST_OUT1 && out_fire)
            begin
                ch_a_reg       <= INIT_A;
                ch_b_reg       <= INIT_B;
                ch_c_reg       <= INIT_C;
                ch_d_reg       <= INIT_D;
                count_reg      <= '0;
                pad_active_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            word_reg <= word_next;
        end
        if (in_fire && byte_ch.message_end)
        begin
            total_reg <= count_next;
        end

        if (state_reg != ST_COMP)
        begin
            a_reg <= ch_a_reg;
            b_reg <= ch_b_reg;
            c_reg <= ch_c_reg;
            d_reg <= ch_d_reg;
        end
        else if (cyc_reg >= 7'd2)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end

        if (state_reg == ST_COMP && cyc_reg >= 7'd1)
        begin
            pre_reg <= ((cyc_reg == 7'd1) ? a_reg : d_reg) + ram_rdata + k_const(pre_step);
        end
    end

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(byte_ch.ready && digest_ch.valid))
        else $error("byte channel ready while a digest is pending");

    a_cycle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cyc_reg <= LAST_CYCLE)
        else $error("compression step counter overran");

    a_digest_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT0) |-> (pad_active_reg && len_done_reg && pos_reg == 6'd0))
        else $error("digest issued before padding completed");

    a_comp_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COMP && state_next == ST_COMP) |-> (pos_reg == LAST_SLOT && put_en))
        else $error("compression started on a partial block");

endmodule
`default_nettype wire
